@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on clk, switched off while rst_n is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tmc_pkg.sv @@
// Types and constants of the tracking mode controller.
// No dependencies; used by the top level and its checker.
package tmc_pkg;

  // Tracking mode, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE      = 8'b0000_0001,
    MODE_SEARCH    = 8'b0000_0010,
    MODE_DETECT    = 8'b0000_0100,
    MODE_ACQUIRE   = 8'b0000_1000,
    MODE_TRACK     = 8'b0001_0000,
    MODE_REACQUIRE = 8'b0010_0000,
    MODE_HANDOVER  = 8'b0100_0000,
    MODE_SAFE      = 8'b1000_0000
  } mode_e;

  // Mode codes as reported on the result
  localparam logic [2:0] MCODE_IDLE      = 3'd0;
  localparam logic [2:0] MCODE_SEARCH    = 3'd1;
  localparam logic [2:0] MCODE_DETECT    = 3'd2;
  localparam logic [2:0] MCODE_ACQUIRE   = 3'd3;
  localparam logic [2:0] MCODE_TRACK     = 3'd4;
  localparam logic [2:0] MCODE_REACQUIRE = 3'd5;
  localparam logic [2:0] MCODE_HANDOVER  = 3'd6;
  localparam logic [2:0] MCODE_SAFE      = 3'd7;

  // Track state codes
  localparam logic [1:0] TS_TENTATIVE = 2'd0;
  localparam logic [1:0] TS_CONFIRMED = 2'd1;
  localparam logic [1:0] TS_COASTING  = 2'd2;
  localparam logic [1:0] TS_DELETED   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANDOVER_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HANDOVER_FRMS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LIMIT  = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic [31:0] LOSS_TIMEOUT_RST   = 32'd5000;
  localparam logic [15:0] DETECT_TIMEOUT_RST = 16'd10;
  localparam logic        HANDOVER_EN_RST    = 1'b0;
  localparam logic [15:0] HANDOVER_FRMS_RST  = 16'd30;
  localparam logic [15:0] CAPTURE_LIMIT_RST  = 16'd256;

  // Input tdata layout
  localparam int unsigned IN_RUN_LSB   = 0;
  localparam int unsigned IN_CAND_LSB  = 1;
  localparam int unsigned IN_HAVE_LSB  = 9;
  localparam int unsigned IN_TS_LSB    = 10;
  localparam int unsigned IN_RMS_LSB   = 12;
  localparam int unsigned IN_TIME_LSB  = 28;
  localparam int unsigned IN_DATA_W    = 64;

  // Output tdata layout
  localparam int unsigned OUT_MODE_LSB   = 0;
  localparam int unsigned OUT_CHG_LSB    = 3;
  localparam int unsigned OUT_FRAMES_LSB = 4;
  localparam int unsigned OUT_TIME_LSB   = 36;
  localparam int unsigned OUT_DATA_W     = 72;

  // Report code of a one-hot mode
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    c = MCODE_IDLE;
    case (m)
      MODE_IDLE:      c = MCODE_IDLE;
      MODE_SEARCH:    c = MCODE_SEARCH;
      MODE_DETECT:    c = MCODE_DETECT;
      MODE_ACQUIRE:   c = MCODE_ACQUIRE;
      MODE_TRACK:     c = MCODE_TRACK;
      MODE_REACQUIRE: c = MCODE_REACQUIRE;
      MODE_HANDOVER:  c = MCODE_HANDOVER;
      MODE_SAFE:      c = MCODE_SAFE;
      default:        c = MCODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ src/track_mode_controller_unit.sv @@
// Tracking mode controller top level; depends on tmc_pkg.
// The result of an accepted input transaction is registered and shows in the cycle after.
// Throughput: one frame per cycle; a stalled result holds off the input until taken.
// Reset (rst_ni low, asynchronous): mode Idle, counters and times zero,
// configuration registers at their defaults, no result pending.
module track_mode_controller_unit #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [tmc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tmc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Frame input
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // run flag, candidates[7:0], track present, track status[1:0],
  // rms_error[15:0], time_ms[31:0], zero fill
  input  logic [tmc_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // Result output
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // mode[2:0], changed, frames_in_mode[31:0], time_in_mode_ms[31:0], zero fill
  output logic [tmc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned HCMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Configuration registers
  logic [31:0] loss_timeout_q;
  logic [15:0] detect_timeout_q;
  logic        handover_en_q;
  logic [15:0] handover_frames_q;
  logic [15:0] capture_limit_q;

  // Mode state
  tmc_pkg::mode_e          mode_q, mode_d;
  logic                    started_q, started_d;
  logic [TIME_BITS-1:0]    last_time_q;
  logic [TIME_BITS-1:0]    last_lock_q, last_lock_d;
  logic [COUNT_BITS-1:0]   empty_cnt_q, empty_cnt_d;
  logic [COUNT_BITS-1:0]   ho_cnt_q, ho_cnt_d;
  logic [31:0]             frames_q, frames_d;
  logic [31:0]             mtime_q, mtime_d;
  logic                    changed_d;

  // Output stage
  logic                            out_valid_q;
  logic [tmc_pkg::OUT_DATA_W-1:0]  out_data_q, out_data_d;

  // Input fields
  logic                  in_run;
  logic [7:0]            in_cand;
  logic                  in_have;
  logic [1:0]            in_ts;
  logic [15:0]           in_rms;
  logic [31:0]           in_time;

  logic                  accept;
  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  dt;
  logic [TIME_BITS-1:0]  since_lock;
  logic                  lock_now;
  logic                  lost;
  logic                  loss;
  logic [COUNT_BITS-1:0] ho_inc;
  tmc_pkg::mode_e        next_mode;
  logic [31:0]           frames_base;
  logic [31:0]           mtime_base;
  logic [CMP_W:0]        mtime_sum;

  assign in_run  = s_axis_tdata_i[tmc_pkg::IN_RUN_LSB];
  assign in_cand = s_axis_tdata_i[tmc_pkg::IN_CAND_LSB +: 8];
  assign in_have = s_axis_tdata_i[tmc_pkg::IN_HAVE_LSB];
  assign in_ts   = s_axis_tdata_i[tmc_pkg::IN_TS_LSB +: 2];
  assign in_rms  = s_axis_tdata_i[tmc_pkg::IN_RMS_LSB +: 16];
  assign in_time = s_axis_tdata_i[tmc_pkg::IN_TIME_LSB +: 32];

  // Take a frame whenever the result register is free or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Per-frame bookkeeping done in every mode
  assign now        = TIME_BITS'(in_time);
  assign dt         = started_q ? (now - last_time_q) : '0;
  assign lock_now   = in_have && (in_ts == tmc_pkg::TS_CONFIRMED ||
                                  in_ts == tmc_pkg::TS_COASTING);
  assign since_lock = now - last_lock_d;
  assign loss       = (mode_q != tmc_pkg::MODE_SAFE) && (mode_q != tmc_pkg::MODE_IDLE) &&
                      (CMP_W'(since_lock) > CMP_W'(loss_timeout_q));
  assign lost       = !in_have || (in_ts == tmc_pkg::TS_DELETED);
  assign ho_inc     = (ho_cnt_q != '1) ? ho_cnt_q + 1'b1 : ho_cnt_q;

  always_comb begin
    if (in_cand != 8'd0) begin
      empty_cnt_d = '0;
    end else if (empty_cnt_q != '1) begin
      empty_cnt_d = empty_cnt_q + 1'b1;
    end else begin
      empty_cnt_d = empty_cnt_q;
    end
  end

  always_comb begin
    last_lock_d = lock_now ? now : last_lock_q;
    if (!started_q && in_run) begin
      last_lock_d = now;
    end
  end

  // Mode transitions of a running frame (loss timeout handled separately)
  always_comb begin
    next_mode = mode_q;
    ho_cnt_d  = ho_cnt_q;
    case (mode_q)
      tmc_pkg::MODE_SEARCH: begin
        if (in_cand != 8'd0) next_mode = tmc_pkg::MODE_DETECT;
      end
      tmc_pkg::MODE_DETECT: begin
        if (!lost) begin
          next_mode = tmc_pkg::MODE_ACQUIRE;
        end else if (HCMP_W'(empty_cnt_d) >= HCMP_W'(detect_timeout_q)) begin
          next_mode = tmc_pkg::MODE_SEARCH;
        end
      end
      tmc_pkg::MODE_ACQUIRE: begin
        if (in_have && in_ts == tmc_pkg::TS_CONFIRMED) begin
          next_mode = tmc_pkg::MODE_TRACK;
        end else if (lost) begin
          next_mode = tmc_pkg::MODE_SEARCH;
        end
      end
      tmc_pkg::MODE_TRACK: begin
        if (lost) begin
          next_mode = tmc_pkg::MODE_SEARCH;
        end else if (in_ts == tmc_pkg::TS_COASTING) begin
          next_mode = tmc_pkg::MODE_REACQUIRE;
        end else if (handover_en_q) begin
          // handover run: count frames with the error inside capture range
          if (in_rms < capture_limit_q) begin
            ho_cnt_d = ho_inc;
            if (HCMP_W'(ho_inc) >= HCMP_W'(handover_frames_q)) begin
              next_mode = tmc_pkg::MODE_HANDOVER;
            end
          end else begin
            ho_cnt_d = '0;
          end
        end
      end
      tmc_pkg::MODE_REACQUIRE: begin
        if (lost) begin
          next_mode = tmc_pkg::MODE_SEARCH;
        end else if (in_ts == tmc_pkg::TS_CONFIRMED) begin
          next_mode = tmc_pkg::MODE_TRACK;
        end
      end
      tmc_pkg::MODE_HANDOVER: begin
        if (lost) begin
          next_mode = tmc_pkg::MODE_SEARCH;
        end else if (in_ts == tmc_pkg::TS_COASTING) begin
          next_mode = tmc_pkg::MODE_REACQUIRE;
        end
      end
      default: begin
        next_mode = mode_q;
      end
    endcase
  end

  // Saturating frame and time counts for a frame that stays running
  assign frames_base = (next_mode != mode_q) ? 32'd0 : frames_q;
  assign mtime_base  = (next_mode != mode_q) ? 32'd0 : mtime_q;
  assign mtime_sum   = {1'b0, CMP_W'(mtime_base)} + {1'b0, CMP_W'(dt)};

  // Select the outcome of the frame
  always_comb begin
    mode_d    = mode_q;
    started_d = started_q;
    frames_d  = frames_q;
    mtime_d   = mtime_q;
    changed_d = 1'b0;
    if (!started_q) begin
      if (in_run) begin
        started_d = 1'b1;
        mode_d    = tmc_pkg::MODE_SEARCH;
        changed_d = 1'b1;
        frames_d  = 32'd1;
        mtime_d   = 32'd0;
      end
    end else if (loss) begin
      mode_d    = tmc_pkg::MODE_SAFE;
      changed_d = 1'b1;
      frames_d  = 32'd1;
      mtime_d   = 32'(dt);
    end else begin
      mode_d    = next_mode;
      changed_d = (next_mode != mode_q);
      frames_d  = (frames_base != '1) ? frames_base + 32'd1 : frames_base;
      if (mtime_sum > (CMP_W+1)'(32'hFFFF_FFFF)) begin
        mtime_d = '1;
      end else begin
        mtime_d = mtime_sum[31:0];
      end
    end
  end

  // Handover count clears on any mode change
  logic [COUNT_BITS-1:0] ho_cnt_sel;
  assign ho_cnt_sel = (mode_d != mode_q) ? '0 : ho_cnt_d;

  always_comb begin
    out_data_d = '0;
    out_data_d[tmc_pkg::OUT_MODE_LSB +: 3]    = tmc_pkg::mode_code(mode_d);
    out_data_d[tmc_pkg::OUT_CHG_LSB]          = changed_d;
    out_data_d[tmc_pkg::OUT_FRAMES_LSB +: 32] = frames_d;
    out_data_d[tmc_pkg::OUT_TIME_LSB +: 32]   = mtime_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_timeout_q    <= tmc_pkg::LOSS_TIMEOUT_RST;
      detect_timeout_q  <= tmc_pkg::DETECT_TIMEOUT_RST;
      handover_en_q     <= tmc_pkg::HANDOVER_EN_RST;
      handover_frames_q <= tmc_pkg::HANDOVER_FRMS_RST;
      capture_limit_q   <= tmc_pkg::CAPTURE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmc_pkg::REG_LOSS_TIMEOUT:   loss_timeout_q    <= cfg_data_i[31:0];
        tmc_pkg::REG_DETECT_TIMEOUT: detect_timeout_q  <= cfg_data_i[15:0];
        tmc_pkg::REG_HANDOVER_EN:    handover_en_q     <= cfg_data_i[0];
        tmc_pkg::REG_HANDOVER_FRMS:  handover_frames_q <= cfg_data_i[15:0];
        tmc_pkg::REG_CAPTURE_LIMIT:  capture_limit_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Mode state, updated per accepted frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tmc_pkg::MODE_IDLE;
      started_q   <= 1'b0;
      last_time_q <= '0;
      last_lock_q <= '0;
      empty_cnt_q <= '0;
      ho_cnt_q    <= '0;
      frames_q    <= '0;
      mtime_q     <= '0;
    end else if (accept) begin
      mode_q      <= mode_d;
      started_q   <= started_d;
      last_time_q <= now;
      last_lock_q <= last_lock_d;
      empty_cnt_q <= empty_cnt_d;
      ho_cnt_q    <= ho_cnt_sel;
      frames_q    <= frames_d;
      mtime_q     <= mtime_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ src/tmc_checker.sv @@
// Port-level checker for the tracking mode controller, with its bind.
// Depends on tmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tmc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  logic [2:0]  res_mode;
  logic        res_chg;
  logic [31:0] res_frames;
  logic [31:0] res_time;
  logic        res_stall;
  logic        res_chg_v;
  logic        res_idle_v;
  logic        res_idle_ok;

  assign res_mode   = m_axis_tdata_o[tmc_pkg::OUT_MODE_LSB +: 3];
  assign res_chg    = m_axis_tdata_o[tmc_pkg::OUT_CHG_LSB];
  assign res_frames = m_axis_tdata_o[tmc_pkg::OUT_FRAMES_LSB +: 32];
  assign res_time   = m_axis_tdata_o[tmc_pkg::OUT_TIME_LSB +: 32];

  assign res_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign res_chg_v   = m_axis_tvalid_o && res_chg;
  assign res_idle_v  = m_axis_tvalid_o && (res_mode == tmc_pkg::MCODE_IDLE);
  assign res_idle_ok = !res_chg && (res_frames == 32'd0) && (res_time == 32'd0);

  // A stalled result holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, res_stall |=> $stable(m_axis_tdata_o), "stalled result changed")

  // Reset leaves no result pending
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

  // A mode change restarts the frame count at this frame
  `ASSERT_RST(a_chg_frames, clk_i, rst_ni, res_chg_v |-> res_frames == 32'd1, "count not restarted")

  // Idle never counts and never reports a change
  `ASSERT_RST(a_idle_zero, clk_i, rst_ni, res_idle_v |-> res_idle_ok, "idle result with counts")

endmodule

bind track_mode_controller_unit tmc_checker u_tmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ dv/tb_track_mode_controller_unit.sv @@
// Self-checking testbench for track_mode_controller_unit: frames go in on the
// input stream, each result is checked against an in-bench mode predictor.
// Depends on tmc_pkg and the RTL top level only.
module tb_track_mode_controller_unit;

  // Input frame, last field in the lowest bits (matches the input tdata layout)
  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] rms;
    logic [1:0]  ts;
    logic        have;
    logic [7:0]  cand;
    logic        run;
  } frame_t;

  // Result, last field in the lowest bits (matches the output tdata layout)
  typedef struct packed {
    logic [31:0] time_in_mode;
    logic [31:0] frames_in_mode;
    logic        changed;
    logic [2:0]  mode;
  } result_t;

  // DUT connections; the inputs driven by the bench are known from time zero
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [tmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [tmc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [tmc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [tmc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  track_mode_controller_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predictor copy of the configuration
  logic [31:0] cfg_loss    = tmc_pkg::LOSS_TIMEOUT_RST;
  logic [15:0] cfg_detect  = tmc_pkg::DETECT_TIMEOUT_RST;
  logic        cfg_ho_en   = tmc_pkg::HANDOVER_EN_RST;
  logic [15:0] cfg_ho_frms = tmc_pkg::HANDOVER_FRMS_RST;
  logic [15:0] cfg_capture = tmc_pkg::CAPTURE_LIMIT_RST;

  // Predictor copy of the mode state
  logic [2:0]  st_mode = tmc_pkg::MCODE_IDLE;
  logic        st_started = 1'b0;
  logic        st_changed = 1'b0;
  logic [31:0] st_last_time = '0;
  logic [31:0] st_lock_time = '0;
  logic [15:0] st_empty = '0;
  logic [15:0] st_handover = '0;
  logic [31:0] st_frames = '0;
  logic [31:0] st_time = '0;
  int          mode_entries [8];

  // Stimulus and scoreboard
  frame_t  pending_frames_q[$];
  result_t mode_results_q[$];
  frame_t  frame_held;
  int      n_pushed = 0;
  int      n_accepted = 0;
  int      n_results = 0;
  int      n_errors = 0;
  int      src_gap = 0;
  int      sink_gap = 0;
  bit      idle_on = 1'b1;
  bit      big_jumps = 1'b0;
  logic [31:0] now_ms = 32'hFFFF_FF60;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Mode change: restart counts and the handover run
  function automatic void set_mode(logic [2:0] nxt);
    if (nxt != st_mode) begin
      st_mode     = nxt;
      st_changed  = 1'b1;
      st_frames   = '0;
      st_time     = '0;
      st_handover = '0;
      mode_entries[nxt]++;
    end
  endfunction

  // One frame through the mode controller; returns the expected result
  function automatic result_t predict_mode_step(frame_t f);
    logic [31:0] dt;
    logic [31:0] since_lock;
    logic [32:0] sum;
    logic        lost;
    result_t     r;
    st_changed = 1'b0;
    dt = st_started ? f.time_ms - st_last_time : 32'd0;
    st_last_time = f.time_ms;
    if (f.cand != '0) st_empty = '0;
    else if (st_empty != '1) st_empty++;
    if (f.have && (f.ts == tmc_pkg::TS_CONFIRMED || f.ts == tmc_pkg::TS_COASTING))
      st_lock_time = f.time_ms;
    since_lock = f.time_ms - st_lock_time;
    lost = !f.have || f.ts == tmc_pkg::TS_DELETED;
    if (!st_started) begin
      // idle until the first running frame
      if (f.run) begin
        st_started   = 1'b1;
        st_lock_time = f.time_ms;
        set_mode(tmc_pkg::MCODE_SEARCH);
        st_frames = 32'd1;
      end
    end else if (st_mode != tmc_pkg::MCODE_SAFE && st_mode != tmc_pkg::MCODE_IDLE &&
                 since_lock > cfg_loss) begin
      // loss timeout wins over every other rule
      set_mode(tmc_pkg::MCODE_SAFE);
      st_frames = 32'd1;
      st_time   = dt;
    end else begin
      case (st_mode)
        tmc_pkg::MCODE_SEARCH: begin
          if (f.cand != '0) set_mode(tmc_pkg::MCODE_DETECT);
        end
        tmc_pkg::MCODE_DETECT: begin
          if (!lost) set_mode(tmc_pkg::MCODE_ACQUIRE);
          else if (st_empty >= cfg_detect) set_mode(tmc_pkg::MCODE_SEARCH);
        end
        tmc_pkg::MCODE_ACQUIRE: begin
          if (f.have && f.ts == tmc_pkg::TS_CONFIRMED) set_mode(tmc_pkg::MCODE_TRACK);
          else if (lost) set_mode(tmc_pkg::MCODE_SEARCH);
        end
        tmc_pkg::MCODE_TRACK: begin
          if (lost) begin
            set_mode(tmc_pkg::MCODE_SEARCH);
          end else if (f.ts == tmc_pkg::TS_COASTING) begin
            set_mode(tmc_pkg::MCODE_REACQUIRE);
          end else if (cfg_ho_en) begin
            if (f.rms < cfg_capture) begin
              if (st_handover != '1) st_handover++;
              if (st_handover >= cfg_ho_frms) set_mode(tmc_pkg::MCODE_HANDOVER);
            end else begin
              st_handover = '0;
            end
          end
        end
        tmc_pkg::MCODE_REACQUIRE: begin
          if (lost) set_mode(tmc_pkg::MCODE_SEARCH);
          else if (f.ts == tmc_pkg::TS_CONFIRMED) set_mode(tmc_pkg::MCODE_TRACK);
        end
        tmc_pkg::MCODE_HANDOVER: begin
          if (lost) set_mode(tmc_pkg::MCODE_SEARCH);
          else if (f.ts == tmc_pkg::TS_COASTING) set_mode(tmc_pkg::MCODE_REACQUIRE);
        end
        default: ;
      endcase
      // saturating frame and time counts
      if (st_frames != '1) st_frames++;
      sum = {1'b0, st_time} + {1'b0, dt};
      st_time = sum[32] ? '1 : sum[31:0];
    end
    r.mode           = st_mode;
    r.changed        = st_changed;
    r.frames_in_mode = st_frames;
    r.time_in_mode   = st_time;
    return r;
  endfunction

  // One line per mismatch, counted
  task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
    $display("%0t: result %0d: %s: got 0x%0h, expected 0x%0h", $realtime, idx, what, got, want);
    n_errors++;
  endtask

  // Input driver: holds a frame until accepted, predicts on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        mode_results_q.insert(mode_results_q.size(), predict_mode_step(frame_held));
        n_accepted++;
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_frames_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 17);
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_frames_q.size() != 0) begin
          frame_held = pending_frames_q.pop_front();
          s_axis_tdata_i  <= tmc_pkg::IN_DATA_W'(frame_held);
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random back-pressure
  always @(posedge clk_i) begin : result_mon
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
        n_results++;
        if (mode_results_q.size() == 0) begin
          report_mismatch("result with none expected", n_results, got.mode, 0);
        end else begin
          want = mode_results_q.pop_front();
          if (got.mode != want.mode)
            report_mismatch("mode", n_results, got.mode, want.mode);
          if (got.changed != want.changed)
            report_mismatch("changed", n_results, got.changed, want.changed);
          if (got.frames_in_mode != want.frames_in_mode)
            report_mismatch("frames_in_mode", n_results, got.frames_in_mode,
                            want.frames_in_mode);
          if (got.time_in_mode != want.time_in_mode)
            report_mismatch("time_in_mode_ms", n_results, got.time_in_mode, want.time_in_mode);
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 17);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Queue one frame, advancing the frame clock by step ms
  task automatic push_frame(logic run, logic [7:0] cand, logic have, logic [1:0] ts,
                            logic [15:0] rms, logic [31:0] step);
    frame_t f;
    now_ms    = now_ms + step;
    f.run     = run;
    f.cand    = cand;
    f.have    = have;
    f.ts      = ts;
    f.rms     = rms;
    f.time_ms = now_ms;
    pending_frames_q.insert(pending_frames_q.size(), f);
    n_pushed++;
  endtask

  function automatic logic [31:0] next_step();
    if (big_jumps && $urandom_range(0, 29) == 0) return $urandom;
    return $urandom_range(0, 60);
  endfunction

  // A short run of frames of one kind: locked, coasting, lost, tentative,
  // empty or fully random
  task automatic push_segment();
    int          pick;
    int          len;
    logic        run;
    logic        have;
    logic [7:0]  cand;
    logic [15:0] rms;
    pick = $urandom_range(0, 99);
    len  = (pick < 35) ? $urandom_range(1, 12) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      run  = $urandom_range(0, 9) != 0;
      cand = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 255));
      if (pick < 35) begin
        // mostly inside the capture limit so handover runs can complete
        if (cfg_capture != '0 && $urandom_range(0, 4) != 0)
          rms = $urandom_range(0, cfg_capture - 1);
        else
          rms = $urandom_range(cfg_capture, 16'hFFFF);
        push_frame(run, cand, 1'b1, tmc_pkg::TS_CONFIRMED, rms, next_step());
      end else if (pick < 47) begin
        push_frame(run, cand, 1'b1, tmc_pkg::TS_COASTING, 16'($urandom), next_step());
      end else if (pick < 59) begin
        have = $urandom_range(0, 1);
        push_frame(run, 8'($urandom_range(0, 1)), have,
                   have ? tmc_pkg::TS_DELETED : 2'($urandom), 16'($urandom), next_step());
      end else if (pick < 71) begin
        push_frame(run, cand, 1'b1, tmc_pkg::TS_TENTATIVE, 16'($urandom), next_step());
      end else if (pick < 83) begin
        push_frame(run, 8'd0, 1'b0, 2'($urandom), 16'($urandom), next_step());
      end else begin
        push_frame(1'($urandom), 8'($urandom), 1'($urandom), 2'($urandom), 16'($urandom),
                   next_step());
      end
    end
  endtask

  task automatic gen_traffic(int n);
    int target;
    target = n_pushed + n;
    while (n_pushed < target) push_segment();
  endtask

  // Block idle: every frame accepted and every result back
  task automatic wait_idle();
    while (n_accepted != n_pushed || mode_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tmc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      tmc_pkg::REG_LOSS_TIMEOUT:   cfg_loss    = val;
      tmc_pkg::REG_DETECT_TIMEOUT: cfg_detect  = val[15:0];
      tmc_pkg::REG_HANDOVER_EN:    cfg_ho_en   = val[0];
      tmc_pkg::REG_HANDOVER_FRMS:  cfg_ho_frms = val[15:0];
      tmc_pkg::REG_CAPTURE_LIMIT:  cfg_capture = val[15:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk with reset settings, starting just below the time wrap
    push_frame(1'b0, 8'd0,   1'b0, tmc_pkg::TS_TENTATIVE, 16'd0,    32'd40);
    push_frame(1'b0, 8'd255, 1'b1, tmc_pkg::TS_CONFIRMED, 16'hFFFF, 32'd40);
    push_frame(1'b1, 8'd0,   1'b0, tmc_pkg::TS_DELETED,   16'd0,    32'd40);
    push_frame(1'b0, 8'd0,   1'b0, tmc_pkg::TS_TENTATIVE, 16'd0,    32'd40);
    push_frame(1'b1, 8'd1,   1'b0, tmc_pkg::TS_CONFIRMED, 16'd0,    32'd40);
    push_frame(1'b1, 8'd0,   1'b1, tmc_pkg::TS_DELETED,   16'd0,    32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_TENTATIVE, 16'd100,  32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_TENTATIVE, 16'd100,  32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_COASTING,  16'd100,  32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_CONFIRMED, 16'd0,    32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_CONFIRMED, 16'd0,    32'd0);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_COASTING,  16'd0,    32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_TENTATIVE, 16'd0,    32'd40);
    push_frame(1'b1, 8'd2,   1'b1, tmc_pkg::TS_CONFIRMED, 16'd0,    32'd40);
    push_frame(1'b1, 8'd0,   1'b0, tmc_pkg::TS_CONFIRMED, 16'd0,    32'd40);
    push_frame(1'b1, 8'd3,   1'b1, tmc_pkg::TS_DELETED,   16'd0,    32'd40);
    push_frame(1'b1, 8'd3,   1'b1, tmc_pkg::TS_CONFIRMED, 16'd0,    32'd40);
    push_frame(1'b1, 8'd0,   1'b1, tmc_pkg::TS_DELETED,   16'd0,    32'd40);
    wait_idle();

    // No timeout, immediate detect timeout, handover on first in-range frame;
    // writes past the register list must be ignored
    write_reg(tmc_pkg::REG_LOSS_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(tmc_pkg::REG_DETECT_TIMEOUT, 32'h0);
    write_reg(tmc_pkg::REG_HANDOVER_EN, 32'hFFFF_FFFF);
    write_reg(tmc_pkg::REG_HANDOVER_FRMS, 32'hFFFF_0000);
    write_reg(tmc_pkg::REG_CAPTURE_LIMIT, 32'hFFFF_FFFF);
    for (int k = tmc_pkg::REG_CAPTURE_LIMIT + 1; k < 2 ** tmc_pkg::CFG_IDX_W; k++)
      write_reg(tmc_pkg::CFG_IDX_W'(k), $urandom);
    close_writes();
    big_jumps = 1'b1;
    gen_traffic(120);
    wait_idle();

    // Moderate settings, handover needs a short run
    write_reg(tmc_pkg::REG_LOSS_TIMEOUT, 32'd20000);
    write_reg(tmc_pkg::REG_DETECT_TIMEOUT, {16'hA5A5, 16'd3});
    write_reg(tmc_pkg::REG_HANDOVER_FRMS, 32'd4);
    write_reg(tmc_pkg::REG_CAPTURE_LIMIT, $urandom_range(256, 4096));
    close_writes();
    big_jumps = 1'b0;
    gen_traffic(150);
    wait_idle();

    // Largest counts, handover off, nothing below a zero capture limit
    write_reg(tmc_pkg::REG_LOSS_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(tmc_pkg::REG_DETECT_TIMEOUT, 32'h0000_FFFF);
    write_reg(tmc_pkg::REG_HANDOVER_EN, 32'h0000_0002);
    write_reg(tmc_pkg::REG_HANDOVER_FRMS, 32'h0000_FFFF);
    write_reg(tmc_pkg::REG_CAPTURE_LIMIT, 32'h0001_0000);
    close_writes();
    big_jumps = 1'b1;
    gen_traffic(60);
    wait_idle();

    // From this part on, both sides run at full rate
    idle_on = 1'b0;
    write_reg(tmc_pkg::REG_LOSS_TIMEOUT, 32'd50000);
    write_reg(tmc_pkg::REG_DETECT_TIMEOUT, $urandom_range(1, 6));
    write_reg(tmc_pkg::REG_HANDOVER_EN, 32'd1);
    write_reg(tmc_pkg::REG_HANDOVER_FRMS, $urandom_range(1, 8));
    write_reg(tmc_pkg::REG_CAPTURE_LIMIT, $urandom);
    close_writes();
    big_jumps = 1'b0;
    gen_traffic(120);
    wait_idle();

    // Zero loss timeout: into Safe, then saturate the time in mode
    write_reg(tmc_pkg::REG_LOSS_TIMEOUT, 32'd0);
    close_writes();
    repeat (3) push_frame(1'b1, 8'd0, 1'b0, tmc_pkg::TS_TENTATIVE, 16'd0, 32'd10);
    repeat (2) push_frame(1'b1, 8'd5, 1'b1, tmc_pkg::TS_CONFIRMED, 16'd0, 32'hF000_0000);
    big_jumps = 1'b1;
    gen_traffic(20);
    wait_idle();
    repeat (5) @(posedge clk_i);

    if (mode_results_q.size() != 0)
      report_mismatch("results never returned", n_results, mode_results_q.size(), 0);
    $display("Ran %0d frames over six register settings, from idle start to safe mode.",
             n_accepted);
    $display(
      "Mode entries: srch %0d det %0d acq %0d trk %0d reacq %0d hand %0d safe %0d",
      mode_entries[tmc_pkg::MCODE_SEARCH], mode_entries[tmc_pkg::MCODE_DETECT],
      mode_entries[tmc_pkg::MCODE_ACQUIRE], mode_entries[tmc_pkg::MCODE_TRACK],
      mode_entries[tmc_pkg::MCODE_REACQUIRE], mode_entries[tmc_pkg::MCODE_HANDOVER],
      mode_entries[tmc_pkg::MCODE_SAFE]);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
